@@ src/ccs_pkg.sv @@
package ccs_pkg;

  localparam int unsigned CharW = 7;
  localparam int unsigned RegW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned StateW = 25;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PHASE_TICKS = 2'd0,
    CFG_START_GAP   = 2'd1,
    CFG_RETRY_LIMIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [StateW-1:0] {
    ST_IDLE         = StateW'(1) << 0,
    ST_START        = StateW'(1) << 1,
    ST_GAP          = StateW'(1) << 2,
    ST_LOAD         = StateW'(1) << 3,
    ST_BIT_DATA     = StateW'(1) << 4,
    ST_BIT_CLK_HI   = StateW'(1) << 5,
    ST_BIT_DATA_LO  = StateW'(1) << 6,
    ST_BIT_CLK_LO   = StateW'(1) << 7,
    ST_PAR_CLK_LO   = StateW'(1) << 8,
    ST_PAR_DATA     = StateW'(1) << 9,
    ST_PAR_CLK_HI   = StateW'(1) << 10,
    ST_PAR_CLK_END  = StateW'(1) << 11,
    ST_ACK_PULSE    = StateW'(1) << 12,
    ST_ACK_PULSE_LO = StateW'(1) << 13,
    ST_RELEASE      = StateW'(1) << 14,
    ST_WAIT1        = StateW'(1) << 15,
    ST_WAIT2        = StateW'(1) << 16,
    ST_WAIT3        = StateW'(1) << 17,
    ST_SAMPLE       = StateW'(1) << 18,
    ST_RECOVER      = StateW'(1) << 19,
    ST_REDRIVE      = StateW'(1) << 20,
    ST_END_WAIT     = StateW'(1) << 21,
    ST_END_HI       = StateW'(1) << 22,
    ST_END_LO       = StateW'(1) << 23,
    ST_DONE         = StateW'(1) << 24
  } state_e;

  typedef struct packed {
    logic [RegW-1:0] phase_ticks;
    logic [RegW-1:0] start_gap_ticks;
    logic [RegW-1:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic clock_out;
    logic clock_enable;
    logic data_out;
    logic data_enable;
    logic advance;
    logic done_res;
    logic error;
    logic busy_res;
  } res_t;

  function automatic logic [RegW-1:0] wait_load(input logic [RegW-1:0] d);
    return (d == '0) ? '0 : d - RegW'(1);
  endfunction

endpackage

@@ src/clocked_serial_char_sender_with_ack.sv @@
// Channel  | valid      | stall       | payload
// input    | in_valid_i | in_stall_o  | begin_req_i, cur_char_i, is_last_i, data_pin_in_i
// output   | out_valid_o| out_stall_i | clock_out_o ... busy_res_o
// config   | cfg_we_i   | (none)      | cfg_idx_i, cfg_data_i
//
// Each input transfer is one base tick and yields one output transfer.
// One transfer is taken per cycle when not stalled; its result is registered for output.
// A two-entry output buffer lets input continue while one result waits.
// Reset returns the sequencer to idle with the registers at their defaults.
// Input stalls only when both output entries are full.
module clocked_serial_char_sender_with_ack
  import ccs_pkg::*;
#(
  parameter int unsigned CHAR_BITS = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               begin_req_i,
  input  logic [CharW-1:0]   cur_char_i,
  input  logic               is_last_i,
  input  logic               data_pin_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               clock_out_o,
  output logic               clock_enable_o,
  output logic               data_out_o,
  output logic               data_enable_o,
  output logic               advance_o,
  output logic               done_res_o,
  output logic               error_o,
  output logic               busy_res_o
);

  cfg_t cfg_q;
  res_t seq_res;
  res_t out_res;
  logic step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks     <= RegW'(5);
      cfg_q.start_gap_ticks <= RegW'(40);
      cfg_q.retry_limit     <= RegW'(5);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PHASE_TICKS: cfg_q.phase_ticks     <= cfg_data_i;
        CFG_START_GAP:   cfg_q.start_gap_ticks <= cfg_data_i;
        CFG_RETRY_LIMIT: cfg_q.retry_limit     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign step = in_valid_i && !in_stall_o;

  ccs_seq #(
    .CHAR_BITS(CHAR_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .begin_req_i  (begin_req_i),
    .cur_char_i   (cur_char_i),
    .is_last_i    (is_last_i),
    .data_pin_in_i(data_pin_in_i),
    .cfg_i        (cfg_q),
    .res_o        (seq_res)
  );

  ccs_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_res_i   (seq_res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res)
  );

  assign clock_out_o    = out_res.clock_out;
  assign clock_enable_o = out_res.clock_enable;
  assign data_out_o     = out_res.data_out;
  assign data_enable_o  = out_res.data_enable;
  assign advance_o      = out_res.advance;
  assign done_res_o     = out_res.done_res;
  assign error_o        = out_res.error;
  assign busy_res_o     = out_res.busy_res;

endmodule

@@ src/ccs_seq.sv @@
module ccs_seq
  import ccs_pkg::*;
#(
  parameter int unsigned CHAR_BITS = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             begin_req_i,
  input  logic [CharW-1:0] cur_char_i,
  input  logic             is_last_i,
  input  logic             data_pin_in_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  localparam logic [2:0] LastBit = 3'(CHAR_BITS - 1);

  state_e           state_q, state_d;
  logic [RegW-1:0]  wait_q, wait_d;
  logic [2:0]       bit_q, bit_d;
  logic             odd_q, odd_d;
  logic [RegW-1:0]  retry_q, retry_d;
  logic [CharW-1:0] char_q, char_d;
  logic             last_q, last_d;
  logic             active_q, active_d;
  logic             clk_lvl_q, clk_lvl_d;
  logic             dat_lvl_q, dat_lvl_d;
  logic             clk_drv_q, clk_drv_d;
  logic             dat_drv_q, dat_drv_d;
  logic             adv, done, err;
  logic [3:0]       sel_idx;
  logic             bit_val;
  logic [RegW-1:0]  p_wait;

  assign sel_idx = 4'(CHAR_BITS - 1) - {1'b0, bit_q};
  assign bit_val = (sel_idx < 4'(CharW)) ? char_q[sel_idx[2:0]] : 1'b0;
  assign p_wait  = wait_load(cfg_i.phase_ticks);

  always_comb begin
    state_d   = state_q;
    wait_d    = wait_q;
    bit_d     = bit_q;
    odd_d     = odd_q;
    retry_d   = retry_q;
    char_d    = char_q;
    last_d    = last_q;
    active_d  = active_q;
    clk_lvl_d = clk_lvl_q;
    dat_lvl_d = dat_lvl_q;
    clk_drv_d = clk_drv_q;
    dat_drv_d = dat_drv_q;
    adv       = 1'b0;
    done      = 1'b0;
    err       = 1'b0;
    if (state_q == ST_IDLE) begin
      if (begin_req_i) begin
        active_d  = 1'b1;
        retry_d   = '0;
        clk_drv_d = 1'b1;
        clk_lvl_d = 1'b1;
        wait_d    = p_wait;
        state_d   = ST_START;
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - RegW'(1);
    end else begin
      wait_d = p_wait;
      case (state_q)
        ST_START: begin
          clk_lvl_d = 1'b0;
          wait_d    = wait_load(cfg_i.start_gap_ticks);
          state_d   = ST_GAP;
        end
        ST_GAP: begin
          dat_drv_d = 1'b1;
          state_d   = ST_LOAD;
        end
        ST_LOAD: begin
          char_d    = cur_char_i;
          last_d    = is_last_i;
          bit_d     = '0;
          odd_d     = 1'b0;
          clk_lvl_d = 1'b0;
          state_d   = ST_BIT_DATA;
        end
        ST_BIT_DATA: begin
          dat_lvl_d = bit_val;
          odd_d     = odd_q ^ bit_val;
          state_d   = ST_BIT_CLK_HI;
        end
        ST_BIT_CLK_HI: begin
          clk_lvl_d = 1'b1;
          state_d   = ST_BIT_DATA_LO;
        end
        ST_BIT_DATA_LO: begin
          dat_lvl_d = 1'b0;
          if (bit_q >= LastBit) begin
            state_d = ST_PAR_CLK_LO;
          end else begin
            bit_d   = bit_q + 3'd1;
            state_d = ST_BIT_CLK_LO;
          end
        end
        ST_BIT_CLK_LO: begin
          clk_lvl_d = 1'b0;
          state_d   = ST_BIT_DATA;
        end
        ST_PAR_CLK_LO: begin
          clk_lvl_d = 1'b0;
          state_d   = ST_PAR_DATA;
        end
        ST_PAR_DATA: begin
          dat_lvl_d = ~odd_q;
          state_d   = ST_PAR_CLK_HI;
        end
        ST_PAR_CLK_HI: begin
          clk_lvl_d = 1'b1;
          state_d   = ST_PAR_CLK_END;
        end
        ST_PAR_CLK_END: begin
          clk_lvl_d = 1'b0;
          state_d   = ST_ACK_PULSE;
        end
        ST_ACK_PULSE: begin
          dat_lvl_d = 1'b1;
          state_d   = ST_ACK_PULSE_LO;
        end
        ST_ACK_PULSE_LO: begin
          dat_lvl_d = 1'b0;
          state_d   = ST_RELEASE;
        end
        ST_RELEASE: begin
          dat_drv_d = 1'b0;
          state_d   = ST_WAIT1;
        end
        ST_WAIT1: state_d = ST_WAIT2;
        ST_WAIT2: state_d = ST_WAIT3;
        ST_WAIT3: state_d = ST_SAMPLE;
        ST_SAMPLE: begin
          state_d = ST_RECOVER;
          if (data_pin_in_i) begin
            adv     = 1'b1;
            retry_d = '0;
          end else begin
            last_d  = 1'b0;
            retry_d = (retry_q == '1) ? retry_q : retry_q + RegW'(1);
            if (retry_d > cfg_i.retry_limit) begin
              err       = 1'b1;
              clk_drv_d = 1'b0;
              dat_lvl_d = 1'b0;
              active_d  = 1'b0;
              state_d   = ST_IDLE;
              wait_d    = '0;
            end
          end
        end
        ST_RECOVER: begin
          clk_lvl_d = 1'b1;
          state_d   = ST_REDRIVE;
        end
        ST_REDRIVE: begin
          dat_drv_d = 1'b1;
          dat_lvl_d = 1'b0;
          state_d   = last_q ? ST_END_WAIT : ST_GAP;
        end
        ST_END_WAIT: state_d = ST_END_HI;
        ST_END_HI: begin
          dat_lvl_d = 1'b1;
          state_d   = ST_END_LO;
        end
        ST_END_LO: begin
          dat_lvl_d = 1'b0;
          state_d   = ST_DONE;
        end
        ST_DONE: begin
          done      = 1'b1;
          clk_drv_d = 1'b0;
          dat_lvl_d = 1'b0;
          active_d  = 1'b0;
          state_d   = ST_IDLE;
          wait_d    = '0;
        end
        default: begin
          clk_drv_d = 1'b0;
          dat_lvl_d = 1'b0;
          active_d  = 1'b0;
          state_d   = ST_IDLE;
          wait_d    = '0;
        end
      endcase
    end
  end

  always_comb begin
    res_o.clock_out    = clk_lvl_d;
    res_o.clock_enable = clk_drv_d;
    res_o.data_out     = dat_lvl_d;
    res_o.data_enable  = dat_drv_d;
    res_o.advance      = adv;
    res_o.done_res     = done;
    res_o.error        = err;
    res_o.busy_res     = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wait_q    <= '0;
      bit_q     <= '0;
      odd_q     <= 1'b0;
      retry_q   <= '0;
      char_q    <= '0;
      last_q    <= 1'b0;
      active_q  <= 1'b0;
      clk_lvl_q <= 1'b0;
      dat_lvl_q <= 1'b0;
      clk_drv_q <= 1'b0;
      dat_drv_q <= 1'b0;
    end else if (step_i) begin
      state_q   <= state_d;
      wait_q    <= wait_d;
      bit_q     <= bit_d;
      odd_q     <= odd_d;
      retry_q   <= retry_d;
      char_q    <= char_d;
      last_q    <= last_d;
      active_q  <= active_d;
      clk_lvl_q <= clk_lvl_d;
      dat_lvl_q <= dat_lvl_d;
      clk_drv_q <= clk_drv_d;
      dat_drv_q <= dat_drv_d;
    end
  end

  a_idle_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> wait_q == '0 && !active_q)
    else $error("idle sequencer holds a pending delay or busy flag");

  a_busy_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (state_q != ST_IDLE))
    else $error("busy flag disagrees with sequencer state");

  a_end_pulse_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.error || res_o.done_res) |=> state_q == ST_IDLE && !clk_drv_q)
    else $error("message end did not return the sequencer to idle");

endmodule

@@ src/ccs_obuf.sv @@
module ccs_obuf
  import ccs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  res_t in_res_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t out_res_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic push;
  logic take;

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign push        = in_valid_i && !skid_valid_q;
  assign take        = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || take) begin
      out_valid_d  = skid_valid_q || push;
      out_d        = skid_valid_q ? skid_q : in_res_i;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = in_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_res_o))
    else $error("stalled output transfer changed");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && take |=> !skid_valid_q)
    else $error("skid entry not moved on after an output transfer");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench
  import ccs_pkg::*;
;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idling_e;

  typedef logic [CharW-1:0] char_q_t [$];

  localparam int unsigned StallLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic begin_req_i = 1'b0;
  logic [CharW-1:0] cur_char_i = '0;
  logic is_last_i = 1'b0;
  logic data_pin_in_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic clock_out_o;
  logic clock_enable_o;
  logic data_out_o;
  logic data_enable_o;
  logic advance_o;
  logic done_res_o;
  logic error_o;
  logic busy_res_o;

  clocked_serial_char_sender_with_ack dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Line sequencer state as the checker tracks it.
  logic [RegW-1:0] phase_cfg, gap_cfg, retry_cfg;
  state_e seq_st;
  logic [RegW-1:0] seq_wait;
  logic [2:0] bit_pos;
  logic ones;
  logic [RegW-1:0] retries;
  logic [CharW-1:0] held_ch;
  logic held_end, busy, clk_lvl, dat_lvl, clk_drv, dat_drv;

  res_t expected_lines [$];
  int fail_count = 0;
  int ticks_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic logic [RegW-1:0] phase_count(logic [RegW-1:0] d);
    return (d > 0) ? d - 8'd1 : '0;
  endfunction

  function automatic void park();
    clk_drv = 1'b0;
    dat_lvl = 1'b0;
    busy = 1'b0;
    seq_st = ST_IDLE;
    seq_wait = '0;
  endfunction

  function automatic void reset_predictor();
    phase_cfg = 8'd5;
    gap_cfg = 8'd40;
    retry_cfg = 8'd5;
    seq_st = ST_IDLE;
    seq_wait = '0;
    bit_pos = '0;
    ones = 1'b0;
    retries = '0;
    held_ch = '0;
    held_end = 1'b0;
    busy = 1'b0;
    clk_lvl = 1'b0;
    dat_lvl = 1'b0;
    clk_drv = 1'b0;
    dat_drv = 1'b0;
  endfunction

  function automatic res_t predict_line_tick(logic go, logic [CharW-1:0] ch, logic fin,
                                             logic pin);
    res_t lines;
    lines = '0;
    if (seq_st == ST_IDLE) begin
      if (go) begin
        busy = 1'b1;
        retries = '0;
        clk_drv = 1'b1;
        clk_lvl = 1'b1;
        seq_wait = phase_count(phase_cfg);
        seq_st = ST_START;
      end
    end else if (seq_wait != '0) begin
      seq_wait = seq_wait - 8'd1;
    end else begin
      seq_wait = phase_count(phase_cfg);
      case (seq_st)
        ST_START: begin
          clk_lvl = 1'b0;
          seq_wait = phase_count(gap_cfg);
          seq_st = ST_GAP;
        end
        ST_GAP: begin
          dat_drv = 1'b1;
          seq_st = ST_LOAD;
        end
        ST_LOAD: begin
          held_ch = ch;
          held_end = fin;
          bit_pos = '0;
          ones = 1'b0;
          clk_lvl = 1'b0;
          seq_st = ST_BIT_DATA;
        end
        ST_BIT_DATA: begin
          dat_lvl = held_ch[CharW - 1 - bit_pos];
          ones = ones ^ dat_lvl;
          seq_st = ST_BIT_CLK_HI;
        end
        ST_BIT_CLK_HI: begin
          clk_lvl = 1'b1;
          seq_st = ST_BIT_DATA_LO;
        end
        ST_BIT_DATA_LO: begin
          dat_lvl = 1'b0;
          if (bit_pos >= CharW - 1) begin
            seq_st = ST_PAR_CLK_LO;
          end else begin
            bit_pos = bit_pos + 3'd1;
            seq_st = ST_BIT_CLK_LO;
          end
        end
        ST_BIT_CLK_LO: begin
          clk_lvl = 1'b0;
          seq_st = ST_BIT_DATA;
        end
        ST_PAR_CLK_LO: begin
          clk_lvl = 1'b0;
          seq_st = ST_PAR_DATA;
        end
        ST_PAR_DATA: begin
          dat_lvl = !ones;
          seq_st = ST_PAR_CLK_HI;
        end
        ST_PAR_CLK_HI: begin
          clk_lvl = 1'b1;
          seq_st = ST_PAR_CLK_END;
        end
        ST_PAR_CLK_END: begin
          clk_lvl = 1'b0;
          seq_st = ST_ACK_PULSE;
        end
        ST_ACK_PULSE: begin
          dat_lvl = 1'b1;
          seq_st = ST_ACK_PULSE_LO;
        end
        ST_ACK_PULSE_LO: begin
          dat_lvl = 1'b0;
          seq_st = ST_RELEASE;
        end
        ST_RELEASE: begin
          dat_drv = 1'b0;
          seq_st = ST_WAIT1;
        end
        ST_WAIT1: seq_st = ST_WAIT2;
        ST_WAIT2: seq_st = ST_WAIT3;
        ST_WAIT3: seq_st = ST_SAMPLE;
        ST_SAMPLE: begin
          if (pin) begin
            lines.advance = 1'b1;
            retries = '0;
            seq_st = ST_RECOVER;
          end else begin
            held_end = 1'b0;
            if (retries != 8'hFF) retries = retries + 8'd1;
            if (retries > retry_cfg) begin
              lines.error = 1'b1;
              park();
            end else begin
              seq_st = ST_RECOVER;
            end
          end
        end
        ST_RECOVER: begin
          clk_lvl = 1'b1;
          seq_st = ST_REDRIVE;
        end
        ST_REDRIVE: begin
          dat_drv = 1'b1;
          dat_lvl = 1'b0;
          seq_st = held_end ? ST_END_WAIT : ST_GAP;
        end
        ST_END_WAIT: seq_st = ST_END_HI;
        ST_END_HI: begin
          dat_lvl = 1'b1;
          seq_st = ST_END_LO;
        end
        ST_END_LO: begin
          dat_lvl = 1'b0;
          seq_st = ST_DONE;
        end
        ST_DONE: begin
          lines.done_res = 1'b1;
          park();
        end
        default: park();
      endcase
    end
    lines.clock_out = clk_lvl;
    lines.clock_enable = clk_drv;
    lines.data_out = dat_lvl;
    lines.data_enable = dat_drv;
    lines.busy_res = busy;
    return lines;
  endfunction

  task automatic check_bit(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      fail_count++;
    end
  endtask

  task automatic compare_lines();
    res_t want;
    if (expected_lines.size() == 0) begin
      $error("output transfer with no expected result");
      fail_count++;
      return;
    end
    want = expected_lines.pop_front();
    check_bit("clock_out", want.clock_out, clock_out_o);
    check_bit("clock_enable", want.clock_enable, clock_enable_o);
    check_bit("data_out", want.data_out, data_out_o);
    check_bit("data_enable", want.data_enable, data_enable_o);
    check_bit("advance", want.advance, advance_o);
    check_bit("done_res", want.done_res, done_res_o);
    check_bit("error", want.error, error_o);
    check_bit("busy_res", want.busy_res, busy_res_o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) compare_lines();
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic set_idling(idling_e mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 59 : (mode == IDLE_BOTH) ? 22 : 0;
    stall_pct = (mode == IDLE_RECEIVER) ? 59 : (mode == IDLE_BOTH) ? 22 : 0;
  endtask

  task automatic send_tick(logic go, logic [CharW-1:0] ch, logic fin, logic pin,
                           output res_t lines);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    begin_req_i <= go;
    cur_char_i <= ch;
    is_last_i <= fin;
    data_pin_in_i <= pin;
    lines = predict_line_tick(go, ch, fin, pin);
    expected_lines.push_back(lines);
    ticks_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic configure(logic [RegW-1:0] phase, logic [RegW-1:0] gap,
                           logic [RegW-1:0] limit);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_lines.size() != 0);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PHASE_TICKS;
    cfg_data_i <= phase;
    @(posedge clk_i);
    cfg_idx_i <= CFG_START_GAP;
    cfg_data_i <= gap;
    @(posedge clk_i);
    cfg_idx_i <= CFG_RETRY_LIMIT;
    cfg_data_i <= limit;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    phase_cfg = phase;
    gap_cfg = gap;
    retry_cfg = limit;
  endtask

  task automatic idle_ticks(int count);
    res_t lines;
    repeat (count) begin
      send_tick(1'b0, 7'($urandom_range(127)), 1'($urandom_range(1)),
                1'($urandom_range(1)), lines);
    end
  endtask

  function automatic char_q_t random_text(int count);
    char_q_t text;
    repeat (count) text.push_back(7'($urandom_range(127)));
    return text;
  endfunction

  // A rowdy source raises begin at random while busy and offers junk
  // between character loads, and now and then marks the wrong character last.
  task automatic run_message(char_q_t chars, int fail_pct, int forced_fails, bit rowdy);
    int pos;
    int samples;
    res_t lines;
    bit at_sample;
    bit at_load;
    logic go, fin, pin;
    logic [CharW-1:0] ch;
    pos = 0;
    samples = 0;
    send_tick(1'b1, chars[0], chars.size() == 1, 1'($urandom_range(1)), lines);
    while (seq_st != ST_IDLE) begin
      at_sample = (seq_st == ST_SAMPLE) && (seq_wait == '0);
      at_load = (seq_st == ST_LOAD) && (seq_wait == '0);
      go = rowdy ? 1'($urandom_range(1)) : 1'b0;
      ch = chars[pos];
      fin = (pos == chars.size() - 1);
      if (rowdy && !at_load) begin
        ch = 7'($urandom_range(127));
        fin = 1'($urandom_range(1));
      end else if (rowdy && $urandom_range(9) == 0) begin
        fin = !fin;
      end
      if (at_sample) begin
        pin = !(samples < forced_fails || $urandom_range(99) < fail_pct);
        samples++;
      end else begin
        pin = 1'($urandom_range(1));
      end
      send_tick(go, ch, fin, pin, lines);
      if (lines.advance && pos < chars.size() - 1) pos++;
    end
  endtask

  task automatic test_default_timing();
    set_idling(IDLE_NONE);
    idle_ticks(4);
    run_message(random_text(2), 0, 0, 1'b0);
  endtask

  task automatic test_char_extremes();
    char_q_t text;
    text = {7'h00, 7'h7F, 7'h55, 7'h2A, 7'h01, 7'h40};
    set_idling(IDLE_SENDER);
    configure(8'd1, 8'd1, 8'd5);
    run_message(text, 0, 0, 1'b0);
  endtask

  task automatic test_zero_delays();
    set_idling(IDLE_RECEIVER);
    configure(8'd0, 8'd0, 8'd1);
    run_message(random_text(3), 20, 0, 1'b0);
  endtask

  task automatic test_begin_while_busy();
    set_idling(IDLE_BOTH);
    configure(8'd1, 8'd2, 8'd5);
    run_message(random_text(3), 30, 0, 1'b1);
  endtask

  task automatic test_retry_exhaustion();
    set_idling(IDLE_BOTH);
    configure(8'd1, 8'd2, 8'd0);
    run_message(random_text(2), 100, 0, 1'b0);
    configure(8'd1, 8'd1, 8'd2);
    run_message(random_text(1), 0, 2, 1'b0);
    run_message(random_text(2), 0, 3, 1'b0);
  endtask

  task automatic test_retry_limit_max();
    set_idling(IDLE_NONE);
    configure(8'd1, 8'd1, 8'd255);
    run_message(random_text(1), 0, 3, 1'b0);
  endtask

  task automatic test_slow_phases();
    set_idling(IDLE_SENDER);
    configure(8'd2, 8'd255, 8'd5);
    run_message(random_text(1), 0, 0, 1'b0);
  endtask

  task automatic test_random_traffic();
    while (ticks_sent < 1900) begin
      set_idling(idling_e'($urandom_range(3)));
      if ($urandom_range(1)) begin
        configure(($urandom_range(3) == 0) ? 8'($urandom_range(4)) : 8'd1,
                  8'($urandom_range(12)), 8'($urandom_range(4)));
      end
      idle_ticks($urandom_range(3));
      run_message(random_text($urandom_range(1, 4)), $urandom_range(50), 0,
                  $urandom_range(5) == 0);
    end
  endtask

  initial begin
    reset_predictor();
    set_idling(IDLE_NONE);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_timing();
    test_char_extremes();
    test_zero_delays();
    test_begin_while_busy();
    test_retry_exhaustion();
    test_retry_limit_max();
    test_slow_phases();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
